// ===== sv/xdec_pkg.sv =====
// ----------------------------------------------------------------------------
// x86 subset decoder package
// Types, opcode constants and result codes shared by the decoder modules.
// ----------------------------------------------------------------------------
package xdec_pkg;

	localparam int ADDR_W = 32;
	localparam logic [31:0] ADDR_MASK =
		(ADDR_W >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_W) - 64'd1);

	typedef enum logic [2:0] {
		PH_START,
		PH_AFTER_REX,
		PH_AFTER_ESC,
		PH_MODRM,
		PH_VALUE
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_UNKNOWN,
		ST_TRUNC
	} status_t;

	typedef enum logic [1:0] {
		PLAN_UNKNOWN,
		PLAN_DONE,
		PLAN_IMM,
		PLAN_MODRM
	} plan_t;

	localparam logic [3:0] REX_HI     = 4'h4;
	localparam logic [3:0] OPH_PSHPOP = 4'h5;
	localparam logic [7:0] OP_ESC     = 8'h0F;

	localparam logic [7:0] OP_ADD_ACC = 8'h05;
	localparam logic [7:0] OP_XOR_ACC = 8'h35;
	localparam logic [7:0] OP_CMP_ACC = 8'h3D;
	localparam logic [7:0] OP_CMP_RM  = 8'h39;
	localparam logic [7:0] OP_PUSH32  = 8'h68;
	localparam logic [7:0] OP_PUSH8   = 8'h6A;
	localparam logic [7:0] OP_JB8     = 8'h72;
	localparam logic [7:0] OP_JE8     = 8'h74;
	localparam logic [7:0] OP_JNE8    = 8'h75;
	localparam logic [7:0] OP_MOV_ST  = 8'h89;
	localparam logic [7:0] OP_MOV_LD  = 8'h8B;
	localparam logic [7:0] OP_GRP_8F  = 8'h8F;
	localparam logic [7:0] OP_NOP     = 8'h90;
	localparam logic [7:0] OP_RET_IMM = 8'hC2;
	localparam logic [7:0] OP_RET     = 8'hC3;
	localparam logic [7:0] OP_INT3    = 8'hCC;
	localparam logic [7:0] OP_CALL    = 8'hE8;
	localparam logic [7:0] OP_JMP32   = 8'hE9;
	localparam logic [7:0] OP_JMP8    = 8'hEB;
	localparam logic [7:0] OP_GRP_F7  = 8'hF7;
	localparam logic [7:0] OP_GRP_FF  = 8'hFF;

	localparam logic [7:0] OP2_JB      = 8'h82;
	localparam logic [7:0] OP2_JE      = 8'h84;
	localparam logic [7:0] OP2_JNE     = 8'h85;
	localparam logic [7:0] OP2_NOP     = 8'h1F;
	localparam logic [7:0] OP2_PUSH_FS = 8'hA0;
	localparam logic [7:0] OP2_POP_FS  = 8'hA1;
	localparam logic [7:0] OP2_PUSH_GS = 8'hA8;
	localparam logic [7:0] OP2_POP_GS  = 8'hA9;

	localparam logic [2:0] GRP_POP  = 3'd0;
	localparam logic [2:0] GRP_MUL  = 3'd4;
	localparam logic [2:0] GRP_CALL = 3'd2;
	localparam logic [2:0] GRP_PUSH = 3'd6;

	localparam logic [1:0] MOD_IND   = 2'd0;
	localparam logic [1:0] MOD_DISP8 = 2'd1;
	localparam logic [1:0] MOD_DISP32 = 2'd2;
	localparam logic [1:0] MOD_REG   = 2'd3;
	localparam logic [2:0] RM_RIP    = 3'b101;
	localparam logic [4:0] RMI_RIP   = 5'd16;

	localparam logic [3:0] MN_ADD     = 4'd0;
	localparam logic [3:0] MN_XOR     = 4'd1;
	localparam logic [3:0] MN_CMP     = 4'd2;
	localparam logic [3:0] MN_PUSH    = 4'd3;
	localparam logic [3:0] MN_POP     = 4'd4;
	localparam logic [3:0] MN_JB      = 4'd5;
	localparam logic [3:0] MN_JE      = 4'd6;
	localparam logic [3:0] MN_JNE     = 4'd7;
	localparam logic [3:0] MN_JMP     = 4'd8;
	localparam logic [3:0] MN_MOV     = 4'd9;
	localparam logic [3:0] MN_NOP     = 4'd10;
	localparam logic [3:0] MN_RET     = 4'd11;
	localparam logic [3:0] MN_INT3    = 4'd12;
	localparam logic [3:0] MN_CALL    = 4'd13;
	localparam logic [3:0] MN_MUL     = 4'd14;
	localparam logic [3:0] MN_UNKNOWN = 4'd15;

	localparam logic [3:0] FM_NONE    = 4'd0;
	localparam logic [3:0] FM_IMM_ACC = 4'd1;
	localparam logic [3:0] FM_IMM     = 4'd2;
	localparam logic [3:0] FM_REL     = 4'd3;
	localparam logic [3:0] FM_OPREG   = 4'd4;
	localparam logic [3:0] FM_REG_REG = 4'd5;
	localparam logic [3:0] FM_RM      = 4'd6;
	localparam logic [3:0] FM_REG_MEM = 4'd7;
	localparam logic [3:0] FM_MEM_REG = 4'd8;
	localparam logic [3:0] FM_MEM     = 4'd9;
	localparam logic [3:0] FM_FS      = 4'd10;
	localparam logic [3:0] FM_GS      = 4'd11;

	typedef struct packed {
		status_t     status;
		logic [4:0]  rex;
		logic        esc;
		logic [7:0]  op;
		logic [7:0]  modrm;
		logic [31:0] value;
		logic [31:0] start;
		logic [3:0]  len;
		logic        blk_start;
		logic [15:0] blk_num;
	} rec_t;

	typedef struct packed {
		logic [31:0]        instr_address;
		logic [3:0]         instr_length;
		logic [3:0]         mnemonic;
		logic [3:0]         operand_form;
		logic [3:0]         reg_index;
		logic [4:0]         rm_index;
		logic               wide_regs;
		logic signed [31:0] value;
		logic [31:0]        branch_target;
		logic               block_start;
		logic [15:0]        block_number;
		status_t            status;
	} res_t;

endpackage

// ===== sv/xdec_parser.sv =====
// ----------------------------------------------------------------------------
// x86 subset decoder byte parser
// Holds the parse state and block labels, consumes one byte per step and
// forms an instruction record when an instruction ends.
// ----------------------------------------------------------------------------
module xdec_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    code_byte,
	input  logic          last_byte,
	output logic          emit,
	output xdec_pkg::rec_t rec
);
	import xdec_pkg::*;

	typedef struct packed {
		plan_t      plan;
		logic [2:0] imm;
	} plan_res_t;

	function automatic plan_res_t opcode_plan(input logic esc, input logic [7:0] op);
		plan_res_t p;
		p.plan = PLAN_UNKNOWN;
		p.imm  = 3'd0;
		if (esc) begin
			unique case (op)
				OP2_JB, OP2_JE, OP2_JNE: begin
					p.plan = PLAN_IMM;
					p.imm  = 3'd4;
				end
				OP2_NOP: p.plan = PLAN_MODRM;
				OP2_PUSH_FS, OP2_POP_FS, OP2_PUSH_GS, OP2_POP_GS: p.plan = PLAN_DONE;
				default: p.plan = PLAN_UNKNOWN;
			endcase
		end else if (op[7:4] == OPH_PSHPOP) begin
			p.plan = PLAN_DONE;
		end else begin
			unique case (op)
				OP_ADD_ACC, OP_XOR_ACC, OP_CMP_ACC, OP_PUSH32, OP_CALL, OP_JMP32: begin
					p.plan = PLAN_IMM;
					p.imm  = 3'd4;
				end
				OP_PUSH8, OP_JB8, OP_JE8, OP_JNE8, OP_JMP8: begin
					p.plan = PLAN_IMM;
					p.imm  = 3'd1;
				end
				OP_RET_IMM: begin
					p.plan = PLAN_IMM;
					p.imm  = 3'd2;
				end
				OP_CMP_RM, OP_MOV_ST, OP_MOV_LD, OP_GRP_8F, OP_GRP_F7, OP_GRP_FF:
					p.plan = PLAN_MODRM;
				OP_NOP, OP_RET, OP_INT3: p.plan = PLAN_DONE;
				default: p.plan = PLAN_UNKNOWN;
			endcase
		end
		return p;
	endfunction

	function automatic logic group_ok(input logic esc, input logic [7:0] op,
		input logic [2:0] reg_f);
		logic ok;
		ok = 1'b1;
		if (!esc) begin
			if (op == OP_GRP_8F)
				ok = (reg_f == GRP_POP);
			else if (op == OP_GRP_F7)
				ok = (reg_f == GRP_MUL);
			else if (op == OP_GRP_FF)
				ok = (reg_f == GRP_CALL) || (reg_f == GRP_PUSH);
		end
		return ok;
	endfunction

	function automatic logic ends_block(input logic esc, input logic [7:0] op);
		logic e;
		if (esc)
			e = (op == OP2_JB) || (op == OP2_JE) || (op == OP2_JNE);
		else
			e = (op == OP_JB8) || (op == OP_JE8) || (op == OP_JNE8) || (op == OP_JMP8) ||
				(op == OP_JMP32) || (op == OP_RET_IMM) || (op == OP_RET);
		return e;
	endfunction

	phase_t      phase_q, n_phase;
	logic [4:0]  rex_q, cur_rex, n_rex;
	logic        esc_q, cur_esc, n_esc;
	logic [7:0]  op_q, cur_op, n_op;
	logic [7:0]  modrm_q, cur_modrm, n_modrm;
	logic [31:0] val_q, cur_val, n_val;
	logic [2:0]  left_q, cur_left, n_left;
	logic [2:0]  size_q, cur_size, n_size;
	logic [31:0] pos_q, start_q, cur_start;
	logic [2:0]  cnt_q, cur_cnt;
	logic        pend_q, n_pend;
	logic [15:0] lbl_q, n_lbl;
	logic        start_ph;
	status_t     st;
	plan_res_t   pr;
	logic [1:0]  idx;
	logic [31:0] ext_val;

	always_comb begin
		start_ph  = (phase_q == PH_START);
		cur_start = start_ph ? pos_q : start_q;
		cur_cnt   = start_ph ? 3'd0 : cnt_q;
		cur_rex   = start_ph ? 5'd0 : rex_q;
		cur_esc   = start_ph ? 1'b0 : esc_q;
		cur_op    = start_ph ? 8'd0 : op_q;
		cur_modrm = start_ph ? 8'd0 : modrm_q;
		cur_val   = start_ph ? 32'd0 : val_q;
		cur_left  = start_ph ? 3'd0 : left_q;
		cur_size  = start_ph ? 3'd0 : size_q;

		n_phase = phase_q;
		n_rex   = cur_rex;
		n_esc   = cur_esc;
		n_op    = cur_op;
		n_modrm = cur_modrm;
		n_val   = cur_val;
		n_left  = cur_left;
		n_size  = cur_size;
		emit    = 1'b0;
		st      = ST_OK;
		pr      = opcode_plan(cur_esc, code_byte);
		idx     = 2'(cur_size - cur_left);

		if (start_ph && code_byte[7:4] == REX_HI) begin
			n_rex   = {1'b1, code_byte[3:0]};
			n_phase = PH_AFTER_REX;
		end else if ((start_ph || phase_q == PH_AFTER_REX) && code_byte == OP_ESC) begin
			n_esc   = 1'b1;
			n_phase = PH_AFTER_ESC;
		end else if (start_ph || phase_q == PH_AFTER_REX || phase_q == PH_AFTER_ESC) begin
			n_op = code_byte;
			unique case (pr.plan)
				PLAN_UNKNOWN: begin
					emit = 1'b1;
					st   = ST_UNKNOWN;
				end
				PLAN_DONE: emit = 1'b1;
				PLAN_IMM: begin
					n_size  = pr.imm;
					n_left  = pr.imm;
					n_phase = PH_VALUE;
				end
				default: n_phase = PH_MODRM;
			endcase
		end else if (phase_q == PH_MODRM) begin
			n_modrm = code_byte;
			if (!group_ok(cur_esc, cur_op, code_byte[5:3])) begin
				emit = 1'b1;
				st   = ST_UNKNOWN;
			end else begin
				unique case (code_byte[7:6])
					MOD_IND: begin
						if (code_byte[2:0] == RM_RIP) begin
							n_size  = 3'd4;
							n_left  = 3'd4;
							n_phase = PH_VALUE;
						end else begin
							emit = 1'b1;
						end
					end
					MOD_DISP8: begin
						n_size  = 3'd1;
						n_left  = 3'd1;
						n_phase = PH_VALUE;
					end
					MOD_DISP32: begin
						n_size  = 3'd4;
						n_left  = 3'd4;
						n_phase = PH_VALUE;
					end
					default: emit = 1'b1;
				endcase
			end
		end else begin
			if (cur_left != 3'd0) begin
				n_val  = cur_val | ({24'd0, code_byte} << {idx, 3'b000});
				n_left = cur_left - 3'd1;
			end
			if (n_left == 3'd0)
				emit = 1'b1;
		end

		if (emit)
			n_phase = PH_START;
		if (last_byte && !emit) begin
			emit = 1'b1;
			st   = ST_TRUNC;
		end

		if (n_size == 3'd1)
			ext_val = {{24{n_val[7]}}, n_val[7:0]};
		else if (n_size == 3'd2)
			ext_val = {{16{n_val[15]}}, n_val[15:0]};
		else
			ext_val = n_val;

		n_lbl  = (pend_q && lbl_q != 16'hFFFF) ? lbl_q + 16'd1 : lbl_q;
		n_pend = emit ? ((st == ST_OK) && ends_block(n_esc, n_op)) : pend_q;

		rec.status    = st;
		rec.rex       = n_rex;
		rec.esc       = n_esc;
		rec.op        = n_op;
		rec.modrm     = n_modrm;
		rec.value     = ext_val;
		rec.start     = cur_start;
		rec.len       = {1'b0, cur_cnt} + 4'd1;
		rec.blk_start = pend_q;
		rec.blk_num   = n_lbl - 16'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			rex_q   <= '0;
			esc_q   <= 1'b0;
			op_q    <= '0;
			modrm_q <= '0;
			val_q   <= '0;
			left_q  <= '0;
			size_q  <= '0;
			pos_q   <= '0;
			start_q <= '0;
			cnt_q   <= '0;
			pend_q  <= 1'b1;
			lbl_q   <= '0;
		end else if (step) begin
			if (last_byte) begin
				phase_q <= PH_START;
				rex_q   <= '0;
				esc_q   <= 1'b0;
				op_q    <= '0;
				modrm_q <= '0;
				val_q   <= '0;
				left_q  <= '0;
				size_q  <= '0;
				pos_q   <= '0;
				start_q <= '0;
				cnt_q   <= '0;
				pend_q  <= 1'b1;
				lbl_q   <= '0;
			end else begin
				phase_q <= n_phase;
				rex_q   <= n_rex;
				esc_q   <= n_esc;
				op_q    <= n_op;
				modrm_q <= n_modrm;
				val_q   <= n_val;
				left_q  <= n_left;
				size_q  <= n_size;
				pos_q   <= pos_q + 32'd1;
				start_q <= cur_start;
				cnt_q   <= cur_cnt + 3'd1;
				pend_q  <= n_pend;
				if (emit)
					lbl_q <= n_lbl;
			end
		end
	end

endmodule

// ===== sv/xdec_decode.sv =====
// ----------------------------------------------------------------------------
// x86 subset decoder result decode
// Turns an instruction record into mnemonic, operand form, register
// indices, address and branch target.
// ----------------------------------------------------------------------------
module xdec_decode (
	input  xdec_pkg::rec_t rec,
	input  logic [31:0]    base_address,
	output xdec_pkg::res_t res
);
	import xdec_pkg::*;

	logic        w, r, b;
	logic [1:0]  md;
	logic [2:0]  mreg, mrm;
	logic [3:0]  mn, form, regi;
	logic [4:0]  rmi;
	logic        wide;
	logic [31:0] addr, target;

	always_comb begin
		w    = rec.rex[3];
		r    = rec.rex[2];
		b    = rec.rex[0];
		md   = rec.modrm[7:6];
		mreg = rec.modrm[5:3];
		mrm  = rec.modrm[2:0];
		addr = (base_address + rec.start) & ADDR_MASK;

		mn   = MN_UNKNOWN;
		form = FM_NONE;
		regi = 4'd0;
		rmi  = 5'd0;
		wide = 1'b0;

		if (rec.status == ST_OK) begin
			if (rec.esc) begin
				unique case (rec.op)
					OP2_JB: begin mn = MN_JB; form = FM_REL; end
					OP2_JE: begin mn = MN_JE; form = FM_REL; end
					OP2_JNE: begin mn = MN_JNE; form = FM_REL; end
					OP2_NOP: begin mn = MN_NOP; form = FM_RM; end
					OP2_PUSH_FS: begin mn = MN_PUSH; form = FM_FS; end
					OP2_POP_FS: begin mn = MN_POP; form = FM_FS; end
					OP2_PUSH_GS: begin mn = MN_PUSH; form = FM_GS; end
					default: begin mn = MN_POP; form = FM_GS; end
				endcase
			end else if (rec.op[7:4] == OPH_PSHPOP) begin
				mn   = rec.op[3] ? MN_POP : MN_PUSH;
				form = FM_OPREG;
				regi = {b, rec.op[2:0]};
				wide = 1'b1;
			end else begin
				unique case (rec.op)
					OP_ADD_ACC: begin mn = MN_ADD; form = FM_IMM_ACC; wide = w; end
					OP_XOR_ACC: begin mn = MN_XOR; form = FM_IMM_ACC; wide = w; end
					OP_CMP_ACC: begin mn = MN_CMP; form = FM_IMM_ACC; wide = w; end
					OP_CMP_RM: begin mn = MN_CMP; form = FM_REG_MEM; end
					OP_MOV_ST: begin mn = MN_MOV; form = FM_REG_MEM; end
					OP_MOV_LD: begin mn = MN_MOV; form = FM_MEM_REG; end
					OP_PUSH32, OP_PUSH8: begin mn = MN_PUSH; form = FM_IMM; end
					OP_JB8: begin mn = MN_JB; form = FM_REL; end
					OP_JE8: begin mn = MN_JE; form = FM_REL; end
					OP_JNE8: begin mn = MN_JNE; form = FM_REL; end
					OP_JMP8, OP_JMP32: begin mn = MN_JMP; form = FM_REL; end
					OP_CALL: begin mn = MN_CALL; form = FM_REL; end
					OP_GRP_8F: begin mn = MN_POP; form = FM_RM; end
					OP_GRP_F7: begin mn = MN_MUL; form = FM_RM; end
					OP_GRP_FF: begin
						mn   = (mreg == GRP_CALL) ? MN_CALL : MN_PUSH;
						form = FM_RM;
					end
					OP_NOP: mn = MN_NOP;
					OP_RET_IMM: begin mn = MN_RET; form = FM_IMM; end
					OP_RET: mn = MN_RET;
					default: mn = MN_INT3;
				endcase
			end

			if (form == FM_REG_MEM || form == FM_MEM_REG) begin
				if (md == MOD_REG)
					form = FM_REG_REG;
				regi = {r, mreg};
				wide = w;
			end else if (form == FM_RM) begin
				wide = (mn == MN_MUL || mn == MN_NOP) ? w : 1'b1;
				if (md != MOD_REG) begin
					form = FM_MEM;
					wide = 1'b1;
				end
			end

			if (form >= FM_REG_REG && form <= FM_MEM)
				rmi = (md == MOD_IND && mrm == RM_RIP) ? RMI_RIP : {1'b0, b, mrm};
		end

		target = (form == FM_REL) ?
			((addr + {28'd0, rec.len} + rec.value) & ADDR_MASK) : 32'd0;

		res.instr_address = addr;
		res.instr_length  = rec.len;
		res.mnemonic      = mn;
		res.operand_form  = form;
		res.reg_index     = regi;
		res.rm_index      = rmi;
		res.wide_regs     = wide;
		res.value         = (rec.status == ST_OK) ? rec.value : 32'sd0;
		res.branch_target = target;
		res.block_start   = rec.blk_start;
		res.block_number  = rec.blk_num;
		res.status        = rec.status;
	end

endmodule

// ===== sv/x86_subset_instruction_decoder.sv =====
// ----------------------------------------------------------------------------
// x86 subset instruction decoder
// Byte-serial decoder for a subset of x86-64 code; one result per finished,
// unknown or truncated instruction.
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+------------------------------------
//   in      | in  | in_valid/in_stall | code_byte, last_byte
//   cfg     | in  | cfg_wen           | cfg_wdata (base_address)
//   out     | out | out_valid/out_stall | instr_address .. status
//
// One code byte is taken per cycle while in_stall is low; the byte that ends
// an instruction passes the input register, then the parse and decode logic
// into the result register, which raises out_valid for its result.
// Reset clears the parse state, labels, base address and both valid flags.
// A stalled result holds in the result register; the next byte still enters
// and waits only if it would produce a further result.
// ----------------------------------------------------------------------------
module x86_subset_instruction_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  code_byte,
	input  logic        last_byte,
	input  logic        cfg_wen,
	input  logic [31:0] cfg_wdata,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] instr_address,
	output logic [3:0]  instr_length,
	output logic [3:0]  mnemonic,
	output logic [3:0]  operand_form,
	output logic [3:0]  reg_index,
	output logic [4:0]  rm_index,
	output logic        wide_regs,
	output logic signed [31:0] value,
	output logic [31:0] branch_target,
	output logic        block_start,
	output logic [15:0] block_number,
	output logic [1:0]  status
);
	import xdec_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic [31:0] base_q;
	logic        valid_s2;
	res_t        res_s2;
	logic        emit, adv, out_free, accept;
	rec_t        rec;
	res_t        res;

	assign out_free = !valid_s2 || !out_stall;
	assign adv      = valid_s1 && (!emit || out_free);
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	xdec_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.code_byte (byte_s1),
		.last_byte (last_s1),
		.emit      (emit),
		.rec       (rec)
	);

	xdec_decode u_decode (
		.rec          (rec),
		.base_address (base_q),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			base_q   <= '0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !adv);
			valid_s2 <= (adv && emit) || (valid_s2 && out_stall);
			if (cfg_wen)
				base_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= code_byte;
			last_s1 <= last_byte;
		end
		if (adv && emit)
			res_s2 <= res;
	end

	assign out_valid     = valid_s2;
	assign instr_address = res_s2.instr_address;
	assign instr_length  = res_s2.instr_length;
	assign mnemonic      = res_s2.mnemonic;
	assign operand_form  = res_s2.operand_form;
	assign reg_index     = res_s2.reg_index;
	assign rm_index      = res_s2.rm_index;
	assign wide_regs     = res_s2.wide_regs;
	assign value         = res_s2.value;
	assign branch_target = res_s2.branch_target;
	assign block_start   = res_s2.block_start;
	assign block_number  = res_s2.block_number;
	assign status        = res_s2.status;

endmodule
